// File: rtl/rdpf_pkg.sv
// ----------------------------------------------------------------------------
// rdpf_pkg
// Shared types, framing characters and helpers of the remote debug packet
// framer.
// ----------------------------------------------------------------------------
package rdpf_pkg;

  localparam logic [7:0] CharStart   = 8'h24;  // '$'
  localparam logic [7:0] CharEnd     = 8'h23;  // '#'
  localparam logic [7:0] CharConsole = 8'h4f;  // 'O'
  localparam logic [3:0] NibbleMask  = 4'hf;

  // Default depth of the command queue between the front and the back.
  localparam int unsigned FifoDepthDef = 2;

  // One input transfer.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } in_item_t;

  // One output transfer.
  typedef struct packed {
    logic [7:0] out_char;
    logic       packet_end;
  } out_item_t;

  // A classified item, as the front hands it to the back.
  typedef struct packed {
    logic       start;
    logic       hex;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  // Lowercase hex digit of one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [3:0] n;
    n = nib & NibbleMask;
    if (n < 4'd10) begin
      return 8'h30 + {4'h0, n};
    end else begin
      return 8'h57 + {4'h0, n};
    end
  endfunction

endpackage

// File: rtl/rdpf_front.sv
// ----------------------------------------------------------------------------
// rdpf_front
// Accepts payload bytes, tracks packet boundaries and latches the packet kind.
// ----------------------------------------------------------------------------
module rdpf_front import rdpf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  logic     fifo_full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  logic in_packet_q, in_packet_d;
  logic hex_q, hex_d;

  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.start = !in_packet_q;
    cmd_o.hex   = in_packet_q ? hex_q : in_item_i.kind;
    cmd_o.data  = in_item_i.data;
    cmd_o.last  = in_item_i.last;

    in_packet_d = in_packet_q;
    hex_d       = hex_q;
    if (push_o) begin
      // The kind only counts on the first byte of a packet.
      in_packet_d = !in_item_i.last;
      hex_d       = in_item_i.last ? 1'b0 : cmd_o.hex;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      hex_q       <= 1'b0;
    end else begin
      in_packet_q <= in_packet_d;
      hex_q       <= hex_d;
    end
  end

endmodule

// File: rtl/rdpf_fifo.sv
// ----------------------------------------------------------------------------
// rdpf_fifo
// Short command queue between the front and the back of the framer.
// ----------------------------------------------------------------------------
module rdpf_fifo import rdpf_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/rdpf_back.sv
// ----------------------------------------------------------------------------
// rdpf_back
// Character sequencer: walks each queued command through the framing steps,
// keeps the checksum and drives the output register.
// ----------------------------------------------------------------------------
module rdpf_back import rdpf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  typedef enum logic [2:0] {
    S_FIRST,
    S_CONS,
    S_HI,
    S_LO,
    S_END,
    S_SUM_HI,
    S_SUM_LO
  } step_e;

  step_e     step_q, cur_step, nxt_step;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic [7:0] sum_q, sum_d;
  logic [7:0] ch;
  logic       sum_it, end_flag, done, load;

  assign load        = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = load && done;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    // The start marker only exists for the first byte of a packet.
    cur_step = (step_q == S_FIRST && !cmd_i.start) ? S_HI : step_q;
    ch       = 8'h00;
    sum_it   = 1'b0;
    end_flag = 1'b0;
    done     = 1'b0;
    nxt_step = S_FIRST;
    unique case (cur_step)
      S_FIRST: begin
        ch       = CharStart;
        nxt_step = cmd_i.hex ? S_CONS : S_HI;
      end
      S_CONS: begin
        ch       = CharConsole;
        sum_it   = 1'b1;
        nxt_step = S_HI;
      end
      S_HI: begin
        sum_it = 1'b1;
        if (cmd_i.hex) begin
          ch       = hex_digit(cmd_i.data[7:4]);
          nxt_step = S_LO;
        end else begin
          ch       = cmd_i.data;
          nxt_step = S_END;
          done     = !cmd_i.last;
        end
      end
      S_LO: begin
        ch       = hex_digit(cmd_i.data[3:0]);
        sum_it   = 1'b1;
        nxt_step = S_END;
        done     = !cmd_i.last;
      end
      S_END: begin
        ch       = CharEnd;
        nxt_step = S_SUM_HI;
      end
      S_SUM_HI: begin
        ch       = hex_digit(sum_q[7:4]);
        nxt_step = S_SUM_LO;
      end
      S_SUM_LO: begin
        ch       = hex_digit(sum_q[3:0]);
        end_flag = 1'b1;
        done     = 1'b1;
      end
      default: begin
        ch = 8'h00;
      end
    endcase

    if (cur_step == S_FIRST) begin
      sum_d = 8'h00;
    end else if (sum_it) begin
      sum_d = sum_q + ch;
    end else begin
      sum_d = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_FIRST;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      sum_q       <= 8'h00;
    end else if (load) begin
      step_q                <= done ? S_FIRST : nxt_step;
      out_valid_q           <= 1'b1;
      out_item_q.out_char   <= ch;
      out_item_q.packet_end <= end_flag;
      sum_q                 <= sum_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

// File: rtl/remote_debug_packet_framer.sv
// ----------------------------------------------------------------------------
// remote_debug_packet_framer
// Frames payload bytes into "$<body>#<hh>" debugger remote-protocol packets.
// ----------------------------------------------------------------------------
// Each byte passes through the command queue and the output register first.
// Throughput: one character per cycle while the output is ready, set by the output
// sequencer; a byte gives 1 character mid-packet in raw kind, 2 in console kind,
// plus 1 or 2 for the packet header and 3 for the trailer, so 1 to 7 in all.
// Reset clears the packet state, the checksum, the queue and the output.
module remote_debug_packet_framer import rdpf_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // The front classifies each byte as it is taken in: it knows whether the
  // byte opens a packet and which kind the packet has. It can keep taking
  // bytes while the queue has room, so input transfers go on while the back
  // is still spelling out earlier bytes.
  logic fifo_full;
  logic push;
  cmd_t push_cmd;

  // The back pulls one command at a time and emits its characters one per
  // cycle while the output accepts them, into an output register, which frees the
  // queue head only when the final character of that command has been loaded.
  logic cmd_valid;
  logic pop;
  cmd_t head_cmd;

  rdpf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .fifo_full_i(fifo_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  rdpf_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .valid_o    (cmd_valid),
    .head_o     (head_cmd)
  );

  // The checksum lives in the back, next to the characters it covers.
  rdpf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (head_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule
